FILE: rtl/oetc_pkg.sv
// ----------------------------------------------------------------------------
// oetc_pkg
// Shared types and constants for the OOK edge timing capture block.
// ----------------------------------------------------------------------------
package oetc_pkg;

    localparam int FRAME_CHANGES_DEF = 49;

    localparam int TIME_W     = 32;
    localparam int SYNC_MIN_W = 16;
    localparam int SYNC_TOL_W = 12;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int INDEX_W    = 6;
    localparam int REPEAT_W   = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [SYNC_MIN_W-1:0] SYNC_MIN_RST = 16'd5000;
    localparam logic [SYNC_TOL_W-1:0] SYNC_TOL_RST = 12'd200;
    localparam logic [REPEAT_W-1:0]   REPEAT_DONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_TOL = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_DIFF,
        ST_NEAR,
        ST_UPDATE,
        ST_EMIT,
        ST_STORE
    } state_t;

    typedef struct packed {
        logic latch;
        logic calc_gap;
        logic calc_diff;
        logic calc_near;
        logic update;
        logic rd_en;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic rd_last;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/oetc_ram.sv
// ----------------------------------------------------------------------------
// oetc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oetc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/oetc_ctrl.sv
// ----------------------------------------------------------------------------
// oetc_ctrl
// Sequencer: steps one edge through gap, compare and update, then walks the
// frame readout when a complete frame is confirmed.
// ----------------------------------------------------------------------------
module oetc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output oetc_pkg::cmd_t    cmd,
    input  oetc_pkg::status_t status
);

    import oetc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                cmd.calc_gap = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_NEAR;
            end
            ST_NEAR:
            begin
                cmd.calc_near = 1'b1;
                state_next    = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // issue one read per cycle while the output slot frees up
                cmd.rd_en = status.out_free;
                if (status.out_free && status.rd_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/oetc_dp.sv
// ----------------------------------------------------------------------------
// oetc_dp
// Datapath: config registers, gap arithmetic, sync classification, change
// and repeat counters, gap store and the output register.
// ----------------------------------------------------------------------------
module oetc_dp #(
    parameter int FRAME_CHANGES = oetc_pkg::FRAME_CHANGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [oetc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [oetc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [oetc_pkg::TIME_W-1:0]          edge_time_us,
    output logic [oetc_pkg::TIME_W-1:0]          pulse_us,
    output logic [oetc_pkg::INDEX_W-1:0]         pulse_index,
    output logic                                 last_of_frame,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  oetc_pkg::cmd_t                       cmd,
    output oetc_pkg::status_t                    status
);

    import oetc_pkg::*;

    localparam int DEPTH  = FRAME_CHANGES + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CC_W   = $clog2(FRAME_CHANGES + 2);
    localparam int DIFF_W = TIME_W + 1;

    localparam logic [CC_W-1:0]   CC_MAX  = CC_W'(FRAME_CHANGES);
    localparam logic [CC_W-1:0]   CC_FULL = CC_W'(FRAME_CHANGES + 1);
    localparam logic [ADDR_W-1:0] RD_LAST = ADDR_W'(FRAME_CHANGES - 1);

    logic [SYNC_MIN_W-1:0] sync_min_reg;
    logic [SYNC_TOL_W-1:0] sync_tol_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     prev_reg;
    logic [TIME_W-1:0]     gap_reg;
    logic [TIME_W-1:0]     gap0_reg;
    logic                  sync_reg;
    logic [DIFF_W-1:0]     diff_reg;
    logic                  near_reg;
    logic [CC_W-1:0]       cc_reg;
    logic [CC_W-1:0]       cc_next;
    logic [REPEAT_W-1:0]   rc_reg;
    logic [REPEAT_W-1:0]   rc_next;
    logic [DEPTH-1:0]      valid_reg;
    logic [ADDR_W-1:0]     rd_cnt_reg;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_idx_reg;
    logic                  out_last_reg;
    logic                  out_vq_reg;

    logic                  is_rep;
    logic [REPEAT_W-1:0]   rc_inc;
    logic                  rep_done;
    logic                  emit;
    logic [CC_W-1:0]       cc_sync;
    logic [CC_W-1:0]       cc_store;
    logic [REPEAT_W-1:0]   rc_keep;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [TIME_W-1:0]     ram_rdata;
    logic signed [DIFF_W-1:0] tol_pos;
    logic signed [DIFF_W-1:0] tol_neg;
    logic                  out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_min_reg <= SYNC_MIN_RST;
            sync_tol_reg <= SYNC_TOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_MIN: sync_min_reg <= cfg_wdata[SYNC_MIN_W-1:0];
                REG_SYNC_TOL: sync_tol_reg <= cfg_wdata[SYNC_TOL_W-1:0];
            endcase
        end
    end

    // counter update for the item under classification
    always_comb
    begin
        is_rep   = sync_reg && near_reg;
        rc_inc   = rc_reg + REPEAT_W'(1);
        rep_done = is_rep && (rc_inc == REPEAT_DONE);
        emit     = rep_done && (cc_reg == CC_FULL);
        if (is_rep)
        begin
            rc_keep = rep_done ? '0 : rc_inc;
        end
        else
        begin
            rc_keep = rc_reg;
        end
        cc_sync = sync_reg ? '0 : cc_reg;
        // overflow drops both counters
        if (cc_sync > CC_MAX)
        begin
            cc_store = '0;
            rc_next  = '0;
        end
        else
        begin
            cc_store = cc_sync;
            rc_next  = rc_keep;
        end
        cc_next = cc_store + CC_W'(1);
    end

    // tolerance window, exclusive on both sides, no wrap
    assign tol_pos = $signed({{(DIFF_W-SYNC_TOL_W){1'b0}}, sync_tol_reg});
    assign tol_neg = -tol_pos;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            now_reg <= edge_time_us;
        end
        if (cmd.calc_gap)
        begin
            gap_reg <= now_reg - prev_reg;
        end
        if (cmd.calc_diff)
        begin
            sync_reg <= gap_reg > {{(TIME_W-SYNC_MIN_W){1'b0}}, sync_min_reg};
            diff_reg <= {1'b0, gap_reg} - {1'b0, gap0_reg};
        end
        if (cmd.calc_near)
        begin
            near_reg <= ($signed(diff_reg) > tol_neg) && ($signed(diff_reg) < tol_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            gap0_reg  <= '0;
            cc_reg    <= '0;
            rc_reg    <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.calc_gap)
            begin
                prev_reg <= now_reg;
            end
            if (cmd.update)
            begin
                cc_reg <= cc_next;
                rc_reg <= rc_next;
                if (!emit)
                begin
                    valid_reg[cc_store[ADDR_W-1:0]] <= 1'b1;
                    if (cc_store == '0)
                    begin
                        gap0_reg <= gap_reg;
                    end
                end
            end
            if (cmd.store)
            begin
                // drop the emitted frame, then hold the new first gap
                valid_reg[FRAME_CHANGES-1:1] <= '0;
                valid_reg[0]                 <= 1'b1;
                gap0_reg                     <= gap_reg;
            end
        end
    end

    assign ram_we    = (cmd.update && !emit) || cmd.store;
    assign ram_waddr = cmd.store ? '0 : cc_store[ADDR_W-1:0];

    oetc_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (gap_reg),
        .re    (cmd.rd_en),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    // readout: the RAM read register is the output data stage
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.rd_en)
        begin
            out_valid_reg <= 1'b1;
            rd_cnt_reg    <= (rd_cnt_reg == RD_LAST) ? '0 : rd_cnt_reg + ADDR_W'(1);
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            out_idx_reg  <= rd_cnt_reg;
            out_last_reg <= rd_cnt_reg == RD_LAST;
            out_vq_reg   <= valid_reg[rd_cnt_reg];
        end
    end

    assign pulse_us      = ram_rdata & {TIME_W{out_vq_reg}};
    assign pulse_index   = INDEX_W'(out_idx_reg);
    assign last_of_frame = out_last_reg;
    assign out_valid     = out_valid_reg;

    assign status.emit     = emit;
    assign status.rd_last  = rd_cnt_reg == RD_LAST;
    assign status.out_free = out_free;

endmodule

FILE: rtl/ook_edge_timing_capture.sv
// ----------------------------------------------------------------------------
// ook_edge_timing_capture
// Pulse timing receiver for on/off-keyed remote frames.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes one receiver edge per transfer, carrying its
//   free-running microsecond timestamp. The block measures the gap since the
//   previous edge, detects sync gaps against sync_min_us and matches them to
//   the first stored gap within sync_tolerance_us. On every second matching
//   sync with a full frame collected, the m_axis channel delivers
//   FRAME_CHANGES gap transfers, oldest first, with tlast on the final one.
//   After acceptance an edge passes four sequencer steps (gap, compare,
//   window check, counter update) before the next edge is taken.
//   An edge that releases a frame also waits for the readout, which walks
//   the gap RAM one entry per cycle through its read port while m_axis
//   does not stall; a stall on m_axis holds the readout.
//   Reset returns the config registers to 5000 and 200, clears the previous
//   timestamp, both counters and the gap store valid bits; the block is
//   ready for an edge on the first cycle after reset.
//   The config port writes register cfg_index with cfg_wdata on cfg_we.
// ----------------------------------------------------------------------------
module ook_edge_timing_capture #(
    parameter int FRAME_CHANGES = oetc_pkg::FRAME_CHANGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [oetc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [oetc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [oetc_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [31:0] edge_time_us
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [oetc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [31:0] pulse_us,
                                                               // [37:32] pulse_index
    output logic                               m_axis_tlast
);

    import oetc_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic [TIME_W-1:0]    pulse_us;
    logic [INDEX_W-1:0]   pulse_index;

    oetc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    oetc_dp #(
        .FRAME_CHANGES (FRAME_CHANGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .edge_time_us  (s_axis_tdata[TIME_W-1:0]),
        .pulse_us      (pulse_us),
        .pulse_index   (pulse_index),
        .last_of_frame (m_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-TIME_W-INDEX_W){1'b0}}, pulse_index, pulse_us};

`ifndef SYNTHESIS
    // one edge at a time: no new edge right after one is taken
    a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("edge accepted while previous edge in progress");

    // no edge is taken while the frame readout runs
    a_readout_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !s_axis_tready)
        else $error("input ready during frame readout");

    // the frame marker sits on the final gap position
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[37:32] == INDEX_W'(FRAME_CHANGES - 1))
        else $error("tlast on wrong gap position");

    // reads are issued only when the output stage can take the data
    a_read_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !m_axis_tvalid || m_axis_tready)
        else $error("read issued over a pending result");
`endif

endmodule
